[rtl/assert_macros.svh]
// assertion macros for the debug module rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a must hold at every clock outside reset
`define DM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

[rtl/dmac_pkg.sv]
// package for the debug module abstract command core
// types, register indexes and executor codes, no dependencies
package dmac_pkg;

  localparam int HartsDef    = 4;
  localparam int ProgbufDef  = 8;
  localparam int DataDef     = 4;
  localparam int ScratchDef  = 2;

  localparam logic [6:0] ADDR_DATA0      = 7'h04;
  localparam logic [6:0] ADDR_DMCONTROL  = 7'h10;
  localparam logic [6:0] ADDR_DMSTATUS   = 7'h11;
  localparam logic [6:0] ADDR_HARTINFO   = 7'h12;
  localparam logic [6:0] ADDR_ABSTRACTCS = 7'h16;
  localparam logic [6:0] ADDR_COMMAND    = 7'h17;
  localparam logic [6:0] ADDR_AUTOEXEC   = 7'h18;
  localparam logic [6:0] ADDR_HALTSUM0   = 7'h40;

  typedef enum logic [2:0] {
    X_IDLE  = 3'd0,
    X_INIT  = 3'd1,
    X_REQ   = 3'd2,
    X_RESP  = 3'd3,
    X_WAITH = 3'd4
  } xstate_t;

  typedef enum logic [2:0] {
    E_NONE   = 3'd0,
    E_BUSY   = 3'd1,
    E_NOTSUP = 3'd2,
    E_EXC    = 3'd3,
    E_WRONG  = 3'd4,
    E_BUS    = 3'd5
  } cmderr_t;

  // one item of inputs, packed at the top level and queued by the front end
  typedef struct packed {
    logic        acc;
    logic        wr;
    logic [6:0]  addr;
    logic [31:0] wdata;
    logic [3:0]  halted;
    logic [3:0]  avail;
    logic        preq_rdy;
    logic        presp_vld;
    logic        presp_err;
    logic [63:0] prdata;
  } item_t;

endpackage

[rtl/dmac_front.sv]
// front end: two entry input queue toward the executor
// depends on dmac_pkg
module dmac_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dmac_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_take,
  output dmac_pkg::item_t q_item
);
  // two entry queue
  dmac_pkg::item_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule

[rtl/dmac_back.sv]
// back end: register file, abstract command executor, output register
// depends on dmac_pkg and assert_macros.svh
`include "assert_macros.svh"
module dmac_back #(
  parameter int HARTS         = dmac_pkg::HartsDef,
  parameter int PROGBUF_WORDS = dmac_pkg::ProgbufDef,
  parameter int DATA_WORDS    = dmac_pkg::DataDef,
  parameter int SCRATCH_REGS  = dmac_pkg::ScratchDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_take,
  input  dmac_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_rd_data,
  output logic [4:0]      out_hart_control,
  output logic [1:0]      out_hart_select,
  output logic            out_port_req_valid,
  output logic [4:0]      out_port_req_kind,
  output logic [63:0]     out_port_addr,
  output logic [63:0]     out_port_wdata,
  output logic [2:0]      out_port_size,
  output logic            out_port_resp_ready
);
  localparam logic [3:0] HMASK = (HARTS >= 4) ? 4'hF : 4'((1 << HARTS) - 1);
  localparam logic [3:0] DMASK = 4'((1 << DATA_WORDS) - 1);
  localparam logic [15:0] PMASK = 16'((1 << PROGBUF_WORDS) - 1);
  localparam int PBW = (PROGBUF_WORDS > 1) ? $clog2(PROGBUF_WORDS) : 1;

  logic [31:0] data_r [4];
  logic [31:0] data_nxt [4];
  logic [31:0] pb_r [PROGBUF_WORDS];
  logic [31:0] pb_nxt [PROGBUF_WORDS];
  logic [31:0] cmd_r, cmd_nxt;
  dmac_pkg::xstate_t xs_r, xs_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [3:0]  aed_r, aed_nxt;
  logic [15:0] aep_r, aep_nxt;
  logic [6:0]  cf_r, cf_nxt;
  logic [1:0]  hsel_r, hsel_nxt;
  logic [7:0]  kf_r, kf_nxt;
  logic [63:0] raddr_r, raddr_nxt, rdat_r, rdat_nxt;
  logic [2:0]  rsz_r, rsz_nxt;
  logic [1:0]  hs_r, hs_nxt;
  logic        ov_r;
  logic [31:0] rd;
  logic        step;

  // output register: one result per item, next one taken while it waits only if it leaves
  assign q_take = q_valid && (!ov_r || !out_stall);
  assign step   = q_take;

  logic [3:0] halted, avail;
  logic       hb, ab, hn, trig;
  logic [1:0] nsel;
  logic [3:0] kdat;
  logic [3:0] kpb;
  logic [7:0] ctype;
  logic [2:0] sz;
  logic [63:0] incaddr;

  always_comb begin
    halted = q_item.halted & HMASK;
    avail  = q_item.avail & HMASK;
    hb = halted[hsel_r];
    ab = avail[hsel_r];
    for (int i = 0; i < 4; i++) data_nxt[i] = data_r[i];
    for (int i = 0; i < PROGBUF_WORDS; i++) pb_nxt[i] = pb_r[i];
    cmd_nxt = cmd_r; xs_nxt = xs_r; err_nxt = err_r; aed_nxt = aed_r; aep_nxt = aep_r;
    cf_nxt = cf_r; hsel_nxt = hsel_r; kf_nxt = kf_r; raddr_nxt = raddr_r;
    rdat_nxt = rdat_r; rsz_nxt = rsz_r; hs_nxt = hs_r;
    rd = 32'd0; trig = 1'b0;
    nsel = q_item.wdata[17:16];
    hn = halted[nsel];
    kdat = 4'(q_item.addr - dmac_pkg::ADDR_DATA0);
    kpb = q_item.addr[3:0];
    ctype = cmd_r[31:24];
    sz = cmd_r[22:20];
    incaddr = {data_r[3], data_r[2]} + ((sz <= 3'd3) ? (64'd1 << sz) : 64'd0);

    if (cf_r[1] && hb) cf_nxt[1] = 1'b0;
    if (cf_r[2] && !hb) begin
      cf_nxt[2] = 1'b0;
      cf_nxt[5] = 1'b1;
    end

    if (q_item.acc) begin
      if (q_item.addr >= dmac_pkg::ADDR_DATA0 &&
          q_item.addr <= dmac_pkg::ADDR_DATA0 + 7'd3) begin
        rd = data_r[kdat[1:0]];
        if (q_item.wr) data_nxt[kdat[1:0]] = q_item.wdata;
        if (aed_r[kdat[1:0]]) trig = 1'b1;
      end else if (q_item.addr == dmac_pkg::ADDR_DMCONTROL) begin
        rd = {2'b0, cf_r[4], 11'd0, hsel_r, 14'd0, cf_r[0], cf_r[6]};
        if (q_item.wr) begin
          if (q_item.wdata[31]) begin
            if (!(q_item.wdata[1] || cf_r[0]) && hn) err_nxt = dmac_pkg::E_WRONG;
            else cf_nxt[1] = 1'b1;
          end else if (q_item.wdata[30]) begin
            if (hn) begin
              cf_nxt[2] = 1'b1;
              cf_nxt[5] = 1'b0;
            end else err_nxt = dmac_pkg::E_WRONG;
          end
          cf_nxt[4] = q_item.wdata[29];
          hsel_nxt = nsel;
          if (q_item.wdata[3]) cf_nxt[3] = 1'b1;
          else if (q_item.wdata[2]) cf_nxt[3] = 1'b0;
          cf_nxt[0] = q_item.wdata[1];
          cf_nxt[6] = q_item.wdata[0];
        end
      end else if (q_item.addr == dmac_pkg::ADDR_DMSTATUS) begin
        rd = {14'd0, cf_r[5], cf_r[5], {4{~ab}}, {2{~hb & ab}}, {2{hb & ab}},
              8'b1010_0010};
      end else if (q_item.addr == dmac_pkg::ADDR_HARTINFO) begin
        if (ab) rd = {8'd0, 4'(SCRATCH_REGS), 20'd0};
      end else if (q_item.addr == dmac_pkg::ADDR_ABSTRACTCS) begin
        rd = {3'd0, 5'(PROGBUF_WORDS), 11'd0, (xs_r != dmac_pkg::X_IDLE), 1'b0, err_r,
              4'd0, 4'(DATA_WORDS)};
        if (q_item.wr) err_nxt = err_r & ~q_item.wdata[10:8];
      end else if (q_item.addr == dmac_pkg::ADDR_COMMAND) begin
        if (q_item.wr && err_r == dmac_pkg::E_NONE) begin
          if (xs_r != dmac_pkg::X_IDLE) err_nxt = dmac_pkg::E_BUSY;
          else begin
            cmd_nxt = q_item.wdata;
            xs_nxt = dmac_pkg::X_INIT;
          end
        end
      end else if (q_item.addr == dmac_pkg::ADDR_AUTOEXEC) begin
        rd = {aep_r, 12'd0, aed_r};
        if (q_item.wr) begin
          aed_nxt = q_item.wdata[3:0] & DMASK;
          aep_nxt = q_item.wdata[31:16] & PMASK;
        end
      end else if (q_item.addr[6:4] == 3'd2) begin
        if (32'(kpb) < PROGBUF_WORDS) begin
          rd = pb_r[kpb[PBW-1:0]];
          if (q_item.wr) pb_nxt[kpb[PBW-1:0]] = q_item.wdata;
          if (aep_r[kpb]) trig = 1'b1;
        end
      end else if (q_item.addr == dmac_pkg::ADDR_HALTSUM0) begin
        rd = {28'd0, halted};
      end
    end
    if (trig && err_r == dmac_pkg::E_NONE) begin
      if (xs_r != dmac_pkg::X_IDLE) err_nxt = dmac_pkg::E_BUSY;
      else xs_nxt = dmac_pkg::X_INIT;
    end

    // executor wins over the register access
    unique case (xs_r)
      dmac_pkg::X_IDLE: begin
        kf_nxt = 8'd0;
        hs_nxt = 2'd0;
      end
      dmac_pkg::X_INIT: begin
        kf_nxt[7] = cmd_r[19];
        if (ctype == 8'd0) begin
          if (cmd_r[17]) begin
            xs_nxt = dmac_pkg::X_REQ;
            kf_nxt[1] = 1'b1;
            kf_nxt[6] = ~cmd_r[16];
            kf_nxt[0] = cmd_r[16];
            hs_nxt[0] = 1'b1;
            raddr_nxt = {48'd0, cmd_r[15:0]};
            rdat_nxt = {data_r[1], data_r[0]};
            rsz_nxt = sz;
          end else if (cmd_r[18]) begin
            xs_nxt = dmac_pkg::X_REQ;
            hs_nxt[0] = 1'b1;
            kf_nxt[4] = 1'b1;
          end else xs_nxt = dmac_pkg::X_IDLE;
        end else if (ctype == 8'd1) begin
          if (hb) begin
            err_nxt = dmac_pkg::E_WRONG;
            xs_nxt = dmac_pkg::X_IDLE;
          end else begin
            cf_nxt[1] = 1'b1;
            kf_nxt[5] = 1'b1;
            xs_nxt = dmac_pkg::X_WAITH;
          end
        end else if (ctype == 8'd2) begin
          xs_nxt = dmac_pkg::X_REQ;
          kf_nxt[2] = 1'b1;
          kf_nxt[6] = ~cmd_r[16];
          kf_nxt[0] = cmd_r[16];
          kf_nxt[3] = cmd_r[23];
          hs_nxt[0] = 1'b1;
          raddr_nxt = {data_r[3], data_r[2]};
          rdat_nxt = {data_r[1], data_r[0]};
          rsz_nxt = sz;
        end else begin
          err_nxt = dmac_pkg::E_NOTSUP;
          xs_nxt = dmac_pkg::X_IDLE;
        end
      end
      dmac_pkg::X_REQ: begin
        if (q_item.preq_rdy) begin
          xs_nxt = dmac_pkg::X_RESP;
          hs_nxt = 2'b10;
        end
      end
      dmac_pkg::X_RESP: begin
        if (q_item.presp_vld) begin
          hs_nxt[1] = 1'b0;
          if (kf_r[6]) begin
            unique case (sz)
              3'd0: begin data_nxt[0] = {24'd0, q_item.prdata[7:0]}; data_nxt[1] = 32'd0; end
              3'd1: begin data_nxt[0] = {16'd0, q_item.prdata[15:0]}; data_nxt[1] = 32'd0; end
              3'd2: begin data_nxt[0] = q_item.prdata[31:0]; data_nxt[1] = 32'd0; end
              3'd3: begin
                data_nxt[0] = q_item.prdata[31:0];
                data_nxt[1] = q_item.prdata[63:32];
              end
              default: ;
            endcase
          end
          if (kf_r[7]) begin
            kf_nxt[7] = 1'b0;
            if (ctype == 8'd0) cmd_nxt = {cmd_r[31:16], cmd_r[15:0] + 16'd1};
            else if (ctype == 8'd2) begin
              data_nxt[3] = incaddr[63:32];
              data_nxt[2] = incaddr[31:0];
            end
          end
          if (q_item.presp_err) begin
            xs_nxt = dmac_pkg::X_IDLE;
            err_nxt = kf_r[2] ? dmac_pkg::E_BUS : dmac_pkg::E_EXC;
          end else if (kf_r[1] && cmd_r[18]) begin
            hs_nxt[0] = 1'b1;
            kf_nxt[4] = 1'b1;
            kf_nxt[1] = 1'b0; kf_nxt[0] = 1'b0; kf_nxt[6] = 1'b0;
            xs_nxt = dmac_pkg::X_REQ;
          end else xs_nxt = dmac_pkg::X_IDLE;
          if (kf_r[5]) begin
            cf_nxt[2] = 1'b1;
            cf_nxt[5] = 1'b0;
          end
        end
      end
      dmac_pkg::X_WAITH: begin
        if (hb) begin
          xs_nxt = dmac_pkg::X_REQ;
          hs_nxt[0] = 1'b1;
          kf_nxt[4] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) data_r[i] <= 32'd0;
      for (int i = 0; i < PROGBUF_WORDS; i++) pb_r[i] <= 32'd0;
      cmd_r <= 32'd0; xs_r <= dmac_pkg::X_IDLE; err_r <= 3'd0; aed_r <= 4'd0;
      aep_r <= 16'd0; cf_r <= 7'd0; hsel_r <= 2'd0; kf_r <= 8'd0;
      raddr_r <= 64'd0; rdat_r <= 64'd0; rsz_r <= 3'd0; hs_r <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      if (step) begin
        for (int i = 0; i < 4; i++) data_r[i] <= data_nxt[i];
        for (int i = 0; i < PROGBUF_WORDS; i++) pb_r[i] <= pb_nxt[i];
        cmd_r <= cmd_nxt; xs_r <= xs_nxt; err_r <= err_nxt; aed_r <= aed_nxt;
        aep_r <= aep_nxt; cf_r <= cf_nxt; hsel_r <= hsel_nxt; kf_r <= kf_nxt;
        raddr_r <= raddr_nxt; rdat_r <= rdat_nxt; rsz_r <= rsz_nxt; hs_r <= hs_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_rd_data         <= rd;
      out_hart_control    <= cf_nxt[4:0];
      out_hart_select     <= hsel_nxt;
      out_port_req_valid  <= hs_nxt[0];
      out_port_req_kind   <= kf_nxt[4:0];
      out_port_addr       <= raddr_nxt;
      out_port_wdata      <= rdat_nxt;
      out_port_size       <= rsz_nxt;
      out_port_resp_ready <= hs_nxt[1];
    end
  end

  assign out_valid = ov_r;

  `DM_ASSERT(a_idle_no_hs, clk, rst_n, (xs_r == dmac_pkg::X_IDLE) |-> !hs_r[0], "idle with req")
  `DM_ASSERT(a_hs_excl, clk, rst_n, !(hs_r[0] && hs_r[1]), "req and resp both set")
  `DM_ASSERT(a_resp_state, clk, rst_n, hs_r[1] |-> (xs_r == dmac_pkg::X_RESP), "stray resp")
endmodule

[rtl/debug_module_abstract_commands_core.sv]
// debug module abstract command core, top level
// path: an accepted input is held in a queue entry, then in the output register
// throughput: one item per cycle unless out_stall; 2-entry queue, one output register
// reset: synchronous active-low rst_n clears state registers; queue and executor go idle
// depends on dmac_pkg, dmac_front and dmac_back
module debug_module_abstract_commands_core #(
  parameter int HARTS         = dmac_pkg::HartsDef,
  parameter int PROGBUF_WORDS = dmac_pkg::ProgbufDef,
  parameter int DATA_WORDS    = dmac_pkg::DataDef,
  parameter int SCRATCH_REGS  = dmac_pkg::ScratchDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic        in_reg_write,
  input  logic [6:0]  in_reg_addr,
  input  logic [31:0] in_reg_wdata,
  input  logic [3:0]  in_halted_mask,
  input  logic [3:0]  in_available_mask,
  input  logic        in_port_req_ready,
  input  logic        in_port_resp_valid,
  input  logic        in_port_resp_error,
  input  logic [63:0] in_port_rdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rd_data,
  output logic [4:0]  out_hart_control,
  output logic [1:0]  out_hart_select,
  output logic        out_port_req_valid,
  output logic [4:0]  out_port_req_kind,
  output logic [63:0] out_port_addr,
  output logic [63:0] out_port_wdata,
  output logic [2:0]  out_port_size,
  output logic        out_port_resp_ready
);
  dmac_pkg::item_t in_item, q_item;
  logic q_valid, q_take;

  assign in_item = '{acc: in_req_type, wr: in_reg_write, addr: in_reg_addr,
                     wdata: in_reg_wdata, halted: in_halted_mask,
                     avail: in_available_mask, preq_rdy: in_port_req_ready,
                     presp_vld: in_port_resp_valid, presp_err: in_port_resp_error,
                     prdata: in_port_rdata};

  dmac_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  dmac_back #(
    .HARTS(HARTS), .PROGBUF_WORDS(PROGBUF_WORDS),
    .DATA_WORDS(DATA_WORDS), .SCRATCH_REGS(SCRATCH_REGS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_rd_data(out_rd_data),
    .out_hart_control(out_hart_control), .out_hart_select(out_hart_select),
    .out_port_req_valid(out_port_req_valid), .out_port_req_kind(out_port_req_kind),
    .out_port_addr(out_port_addr), .out_port_wdata(out_port_wdata),
    .out_port_size(out_port_size), .out_port_resp_ready(out_port_resp_ready)
  );
endmodule

[tb/debug_module_abstract_commands_core_tb.sv]
// self-checking testbench for the debug module abstract command core
// holds its own cycle model of the register file and executor, depends on dmac_pkg
module debug_module_abstract_commands_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CF_NDMRESET = 8'h01, CF_HALTREQ = 8'h02, CF_RESUMEREQ = 8'h04;
  localparam logic [7:0] CF_RESETHALT = 8'h08, CF_HARTRESET = 8'h10, CF_RESUMEACK = 8'h20;
  localparam logic [7:0] CF_DMACTIVE = 8'h40;
  localparam logic [7:0] KF_WRITE = 8'h01, KF_REG = 8'h02, KF_MEM = 8'h04, KF_VIRT = 8'h08;
  localparam logic [7:0] KF_PROG = 8'h10, KF_QUICK = 8'h20, KF_READ = 8'h40;
  localparam logic [7:0] KF_POSTINC = 8'h80;
  localparam logic [1:0] HS_REQV = 2'b01, HS_RESPR = 2'b10;
  localparam logic [6:0] ADDR_PROGBUF0 = 7'h20;
  localparam logic [7:0] CMD_REG = 8'd0, CMD_QUICK = 8'd1, CMD_MEM = 8'd2;

  typedef struct packed {
    logic [3:0][31:0] dw;
    logic [7:0][31:0] pb;
    logic [31:0]      cmd;
    logic [2:0]       xs;
    logic [2:0]       ce;
    logic [3:0]       aed;
    logic [7:0]       aep;
    logic [7:0]       cf;
    logic [1:0]       sel;
    logic [7:0]       kf;
    logic [63:0]      ra;
    logic [63:0]      rdt;
    logic [2:0]       rsz;
    logic [1:0]       hsf;
  } dm_t;

  typedef struct packed {
    logic [31:0] rd;
    logic [4:0]  hc;
    logic [1:0]  hsel;
    logic        rqv;
    logic [4:0]  kind;
    logic [63:0] addr;
    logic [63:0] wdata;
    logic [2:0]  size;
    logic        rr;
  } status_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic in_req_type = 0, in_reg_write = 0;
  logic [6:0] in_reg_addr = '0;
  logic [31:0] in_reg_wdata = '0;
  logic [3:0] in_halted_mask = '0, in_available_mask = '0;
  logic in_port_req_ready = 0, in_port_resp_valid = 0, in_port_resp_error = 0;
  logic [63:0] in_port_rdata = '0;
  logic [31:0] out_rd_data;
  logic [4:0] out_hart_control, out_port_req_kind;
  logic [1:0] out_hart_select;
  logic out_port_req_valid, out_port_resp_ready;
  logic [63:0] out_port_addr, out_port_wdata;
  logic [2:0] out_port_size;

  debug_module_abstract_commands_core DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  dm_t dm;
  status_t status_q[$];
  int errors = 0, sent = 0;
  int idle_pct = 0, stall_pct = 0, hold_cycles = 0;

  function automatic void kick(input dm_t o, inout dm_t n);
    if (o.ce != dmac_pkg::E_NONE) return;
    if (o.xs != dmac_pkg::X_IDLE) n.ce = dmac_pkg::E_BUSY;
    else n.xs = dmac_pkg::X_INIT;
  endfunction

  function automatic void set_resume(inout dm_t n);
    n.cf |= CF_RESUMEREQ;
    n.cf &= ~CF_RESUMEACK;
  endfunction

  function automatic logic [31:0] reg_rw(input dm_t o, inout dm_t n,
                                         input dmac_pkg::item_t it);
    logic [31:0] rd, wd;
    logic hb, ab, hn, ack, na, run, hlt;
    logic [1:0] nxt;
    logic [3:0] k;
    rd = '0;
    wd = it.wdata;
    hb = it.halted[o.sel];
    ab = it.avail[o.sel];
    if (it.addr >= dmac_pkg::ADDR_DATA0 && it.addr <= dmac_pkg::ADDR_DATA0 + 7'd3) begin
      k = 4'(it.addr - dmac_pkg::ADDR_DATA0);
      rd = o.dw[k[1:0]];
      if (it.wr) n.dw[k[1:0]] = wd;
      if (o.aed[k[1:0]]) kick(o, n);
    end else if (it.addr == dmac_pkg::ADDR_DMCONTROL) begin
      rd[29] = o.cf[4];
      rd[17:16] = o.sel;
      rd[1] = o.cf[0];
      rd[0] = o.cf[6];
      if (it.wr) begin
        nxt = wd[17:16];
        hn = it.halted[nxt];
        if (wd[31]) begin
          if (!(wd[1] || o.cf[0]) && hn) n.ce = dmac_pkg::E_WRONG;
          else n.cf |= CF_HALTREQ;
        end else if (wd[30]) begin
          if (hn) set_resume(n);
          else n.ce = dmac_pkg::E_WRONG;
        end
        n.cf[4] = wd[29];
        n.sel = nxt;
        if (wd[3]) n.cf |= CF_RESETHALT;
        else if (wd[2]) n.cf &= ~CF_RESETHALT;
        n.cf[0] = wd[1];
        n.cf[6] = wd[0];
      end
    end else if (it.addr == dmac_pkg::ADDR_DMSTATUS) begin
      ack = o.cf[5];
      na = ~ab;
      run = ~hb & ab;
      hlt = hb & ab;
      rd = {14'b0, ack, ack, na, na, na, na, run, run, hlt, hlt, 8'hA2};
    end else if (it.addr == dmac_pkg::ADDR_HARTINFO) begin
      if (ab) rd = 32'd2 << 20;
    end else if (it.addr == dmac_pkg::ADDR_ABSTRACTCS) begin
      rd = (32'd8 << 24) | ((o.xs != dmac_pkg::X_IDLE) ? 32'h1000 : 32'h0)
         | (32'(o.ce) << 8) | 32'd4;
      if (it.wr) n.ce = n.ce & ~wd[10:8];
    end else if (it.addr == dmac_pkg::ADDR_COMMAND) begin
      if (it.wr && o.ce == dmac_pkg::E_NONE) begin
        if (o.xs != dmac_pkg::X_IDLE) n.ce = dmac_pkg::E_BUSY;
        else begin
          n.cmd = wd;
          n.xs = dmac_pkg::X_INIT;
        end
      end
    end else if (it.addr == dmac_pkg::ADDR_AUTOEXEC) begin
      rd = {8'b0, o.aep, 12'b0, o.aed};
      if (it.wr) begin
        n.aed = wd[3:0];
        n.aep = wd[23:16];
      end
    end else if (it.addr[6:4] == ADDR_PROGBUF0[6:4]) begin
      k = it.addr[3:0];
      if (k < 4'd8) begin
        rd = o.pb[k[2:0]];
        if (it.wr) n.pb[k[2:0]] = wd;
        if (o.aep[k[2:0]]) kick(o, n);
      end
    end else if (it.addr == dmac_pkg::ADDR_HALTSUM0) begin
      rd = {28'b0, it.halted};
    end
    return rd;
  endfunction

  function automatic void start_cmd(input dm_t o, inout dm_t n, input logic hb);
    logic [31:0] c;
    logic w;
    c = o.cmd;
    w = c[16];
    n.kf[7] = c[19];
    if (c[31:24] == CMD_REG) begin
      if (c[17]) begin
        n.xs = dmac_pkg::X_REQ;
        n.kf |= KF_REG;
        n.kf[6] = !w;
        n.kf[0] = w;
        n.hsf |= HS_REQV;
        n.ra = {48'b0, c[15:0]};
        n.rdt = {o.dw[1], o.dw[0]};
        n.rsz = c[22:20];
      end else if (c[18]) begin
        n.xs = dmac_pkg::X_REQ;
        n.hsf |= HS_REQV;
        n.kf |= KF_PROG;
      end else n.xs = dmac_pkg::X_IDLE;
    end else if (c[31:24] == CMD_QUICK) begin
      if (hb) begin
        n.ce = dmac_pkg::E_WRONG;
        n.xs = dmac_pkg::X_IDLE;
      end else begin
        n.cf |= CF_HALTREQ;
        n.kf |= KF_QUICK;
        n.xs = dmac_pkg::X_WAITH;
      end
    end else if (c[31:24] == CMD_MEM) begin
      n.xs = dmac_pkg::X_REQ;
      n.kf |= KF_MEM;
      n.kf[6] = !w;
      n.kf[0] = w;
      n.kf[3] = c[23];
      n.hsf |= HS_REQV;
      n.ra = {o.dw[3], o.dw[2]};
      n.rdt = {o.dw[1], o.dw[0]};
      n.rsz = c[22:20];
    end else begin
      n.ce = dmac_pkg::E_NOTSUP;
      n.xs = dmac_pkg::X_IDLE;
    end
  endfunction

  function automatic void finish_cmd(input dm_t o, inout dm_t n, input logic err,
                                     input logic [63:0] rdata);
    logic [31:0] c;
    logic [2:0] sz;
    logic [63:0] a;
    c = o.cmd;
    sz = c[22:20];
    n.hsf &= ~HS_RESPR;
    if (o.kf & KF_READ) begin
      case (sz)
        3'd0: begin n.dw[0] = {24'b0, rdata[7:0]}; n.dw[1] = '0; end
        3'd1: begin n.dw[0] = {16'b0, rdata[15:0]}; n.dw[1] = '0; end
        3'd2: begin n.dw[0] = rdata[31:0]; n.dw[1] = '0; end
        3'd3: begin n.dw[0] = rdata[31:0]; n.dw[1] = rdata[63:32]; end
        default: ;
      endcase
    end
    if (o.kf & KF_POSTINC) begin
      n.kf &= ~KF_POSTINC;
      if (c[31:24] == CMD_REG) n.cmd = {c[31:16], c[15:0] + 16'd1};
      else if (c[31:24] == CMD_MEM) begin
        a = {o.dw[3], o.dw[2]};
        if (sz <= 3'd3) a += 64'd1 << sz;
        {n.dw[3], n.dw[2]} = a;
      end
    end
    if (err) begin
      n.xs = dmac_pkg::X_IDLE;
      n.ce = (o.kf & KF_MEM) ? dmac_pkg::E_BUS : dmac_pkg::E_EXC;
    end else if ((o.kf & KF_REG) && c[18]) begin
      n.hsf |= HS_REQV;
      n.kf |= KF_PROG;
      n.kf &= ~(KF_REG | KF_WRITE | KF_READ);
      n.xs = dmac_pkg::X_REQ;
    end else n.xs = dmac_pkg::X_IDLE;
    if (o.kf & KF_QUICK) set_resume(n);
  endfunction

  // advances the model by one accepted item and returns the visible status
  function automatic status_t dm_cycle(input dmac_pkg::item_t it);
    dm_t o, n;
    logic hb;
    status_t s;
    o = dm;
    n = dm;
    hb = it.halted[o.sel];
    s.rd = '0;
    if (o.cf[1] && hb) n.cf &= ~CF_HALTREQ;
    if (o.cf[2] && !hb) begin
      n.cf &= ~CF_RESUMEREQ;
      n.cf |= CF_RESUMEACK;
    end
    if (it.acc) s.rd = reg_rw(o, n, it);
    case (o.xs)
      dmac_pkg::X_IDLE: begin n.kf = '0; n.hsf = '0; end
      dmac_pkg::X_INIT: start_cmd(o, n, hb);
      dmac_pkg::X_REQ: if (it.preq_rdy) begin
        n.xs = dmac_pkg::X_RESP;
        n.hsf = (n.hsf & ~HS_REQV) | HS_RESPR;
      end
      dmac_pkg::X_RESP: if (it.presp_vld) finish_cmd(o, n, it.presp_err, it.prdata);
      dmac_pkg::X_WAITH: if (hb) begin
        n.xs = dmac_pkg::X_REQ;
        n.hsf |= HS_REQV;
        n.kf |= KF_PROG;
      end
      default: ;
    endcase
    dm = n;
    s.hc = n.cf[4:0];
    s.hsel = n.sel;
    s.rqv = n.hsf[0];
    s.kind = n.kf[4:0];
    s.addr = n.ra;
    s.wdata = n.rdt;
    s.size = n.rsz;
    s.rr = n.hsf[1];
    return s;
  endfunction

  task automatic send(input dmac_pkg::item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    {in_req_type, in_reg_write, in_reg_addr, in_reg_wdata, in_halted_mask,
     in_available_mask, in_port_req_ready, in_port_resp_valid, in_port_resp_error,
     in_port_rdata} = it;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    status_q.push_back(dm_cycle(it));
    sent++;
    @(negedge clk);
  endtask

  task automatic poke(input logic acc, input logic wr, input logic [6:0] addr,
                      input logic [31:0] wd, input logic [3:0] hm);
    dmac_pkg::item_t it;
    it = '{acc, wr, addr, wd, hm, 4'hF, 1'b1, 1'b1, 1'b0, {$urandom, $urandom}};
    send(it);
  endtask

  function automatic logic [31:0] rand_cmd();
    logic [7:0] ty;
    case ($urandom_range(0, 7))
      0, 1, 2: ty = CMD_REG;
      3, 4: ty = CMD_MEM;
      5: ty = CMD_QUICK;
      default: ty = 8'($urandom_range(3, 255));
    endcase
    return {ty, 24'($urandom)};
  endfunction

  function automatic dmac_pkg::item_t rand_item(input bit quiet);
    dmac_pkg::item_t it;
    it.acc = quiet ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) < 7);
    it.wr = 1'($urandom_range(0, 1));
    it.wdata = $urandom;
    case ($urandom_range(0, 10))
      0, 1: it.addr = dmac_pkg::ADDR_DATA0 + 7'($urandom_range(0, 3));
      2: it.addr = dmac_pkg::ADDR_DMCONTROL;
      3: it.addr = dmac_pkg::ADDR_DMSTATUS;
      4: it.addr = dmac_pkg::ADDR_HARTINFO;
      5: begin
        it.addr = dmac_pkg::ADDR_ABSTRACTCS;
        if ($urandom_range(0, 1)) it.wdata[10:8] = 3'b111;
      end
      6: begin it.addr = dmac_pkg::ADDR_COMMAND; it.wdata = rand_cmd(); end
      7: it.addr = dmac_pkg::ADDR_AUTOEXEC;
      8: it.addr = ADDR_PROGBUF0 + 7'($urandom_range(0, 15));
      9: it.addr = dmac_pkg::ADDR_HALTSUM0;
      default: it.addr = 7'($urandom_range(0, 127));
    endcase
    it.halted = 4'($urandom);
    it.avail = 4'($urandom);
    it.preq_rdy = 1'($urandom_range(0, 1));
    it.presp_vld = 1'($urandom_range(0, 1));
    it.presp_err = ($urandom_range(0, 5) == 0);
    it.prdata = {$urandom, $urandom};
    return it;
  endfunction

  // random command: clear cmderr, load data, issue, let the port answer
  task automatic command_run();
    int n;
    poke(1, 1, dmac_pkg::ADDR_ABSTRACTCS, 32'h700, 4'($urandom));
    if ($urandom_range(0, 3) == 0)
      poke(1, 1, dmac_pkg::ADDR_AUTOEXEC, $urandom, 4'($urandom));
    for (int i = 0; i < 4; i++)
      if ($urandom_range(0, 1))
        poke(1, 1, dmac_pkg::ADDR_DATA0 + 7'(i), $urandom, 4'($urandom));
    poke(1, 1, dmac_pkg::ADDR_COMMAND, rand_cmd(), 4'($urandom));
    n = $urandom_range(3, 10);
    repeat (n) send(rand_item(1));
  endtask

  task automatic drain();
    in_valid = 0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    poke(1, 0, dmac_pkg::ADDR_DMCONTROL, 0, 4'h0);
    poke(1, 0, dmac_pkg::ADDR_DMSTATUS, 0, 4'h0);
    poke(1, 0, dmac_pkg::ADDR_HARTINFO, 0, 4'h0);
    poke(1, 0, dmac_pkg::ADDR_HALTSUM0, 0, 4'hF);
    poke(1, 1, 7'h7F, 32'hFFFF_FFFF, 4'h0);      // unknown register
    poke(1, 1, 7'h2F, 32'hFFFF_FFFF, 4'h0);      // progbuf past the end
    poke(1, 1, dmac_pkg::ADDR_DMCONTROL, 32'h8000_0001, 4'h0);
    poke(1, 0, dmac_pkg::ADDR_DMSTATUS, 0, 4'h1);          // halt seen, haltreq drops
    poke(1, 1, dmac_pkg::ADDR_DMCONTROL, 32'h4000_0001, 4'h1);
    poke(1, 0, dmac_pkg::ADDR_DMSTATUS, 0, 4'h0);          // resumeack
    poke(1, 1, dmac_pkg::ADDR_DMCONTROL, 32'h4003_0001, 4'h0);   // resume a running hart
    poke(1, 1, dmac_pkg::ADDR_DMCONTROL, 32'h2003_000B, 4'h0);
    poke(1, 1, dmac_pkg::ADDR_DMCONTROL, 32'h0000_0005, 4'h0);
    poke(1, 0, dmac_pkg::ADDR_ABSTRACTCS, 0, 4'h0);
    poke(1, 1, dmac_pkg::ADDR_COMMAND, 32'h0300_0000, 4'h0); // command while cmderr set
    poke(1, 1, dmac_pkg::ADDR_ABSTRACTCS, 32'h700, 4'h0);
    poke(1, 1, dmac_pkg::ADDR_COMMAND, 32'hFF00_0000, 4'h0); // unsupported type
    poke(1, 1, dmac_pkg::ADDR_ABSTRACTCS, 32'h700, 4'h0);
    poke(1, 1, dmac_pkg::ADDR_DATA0, 32'hFFFF_FFFF, 4'h0);
    poke(1, 1, dmac_pkg::ADDR_COMMAND, 32'h003F_1000, 4'h0); // regaccess, postinc, postexec
    poke(1, 1, dmac_pkg::ADDR_COMMAND, 32'h0022_0000, 4'h0); // busy
    poke(1, 1, dmac_pkg::ADDR_ABSTRACTCS, 32'h700, 4'h0);
    poke(1, 1, dmac_pkg::ADDR_COMMAND, 32'h02B8_0000, 4'h0); // memaccess read, virt, postinc
    poke(0, 0, dmac_pkg::ADDR_DATA0, 0, 4'h0);
    poke(1, 1, dmac_pkg::ADDR_COMMAND, 32'h0100_0000, 4'h0); // quick access
    poke(0, 0, dmac_pkg::ADDR_DATA0, 0, 4'h1);
    poke(1, 1, dmac_pkg::ADDR_AUTOEXEC, 32'hFFFF_FFFF, 4'h0);
    drain();
  endtask

  task automatic test_random(input int count, input int ip, input int sp);
    int stop;
    idle_pct = ip;
    stall_pct = sp;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 2) != 0) command_run();
      else send(rand_item(0));
    end
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    hold_cycles = 60;
    repeat (30) send(rand_item(0));
    drain();
  endtask

  function automatic void cmp(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1;
      hold_cycles--;
    end else out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    status_t s;
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $display("%0t unexpected result", $time);
        errors++;
      end else begin
        s = status_q.pop_front();
        cmp("rd_data", 64'(s.rd), 64'(out_rd_data));
        cmp("hart_control", 64'(s.hc), 64'(out_hart_control));
        cmp("hart_select", 64'(s.hsel), 64'(out_hart_select));
        cmp("port_req_valid", 64'(s.rqv), 64'(out_port_req_valid));
        cmp("port_req_kind", 64'(s.kind), 64'(out_port_req_kind));
        cmp("port_addr", s.addr, out_port_addr);
        cmp("port_wdata", s.wdata, out_port_wdata);
        cmp("port_size", 64'(s.size), 64'(out_port_size));
        cmp("port_resp_ready", 64'(s.rr), 64'(out_port_resp_ready));
      end
    end
  end

  initial begin
    dm = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(150, 0, 0);
    test_random(150, 52, 0);
    test_backpressure();
    test_random(150, 0, 52);
    test_random(150, 31, 31);
    in_valid = 0;
    repeat (10) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) $display("TB_OK");
    else begin
      if (status_q.size() != 0) $display("%0t %0d results never came", $time, status_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/dmac_pkg.sv
rtl/dmac_front.sv
rtl/dmac_back.sv
rtl/debug_module_abstract_commands_core.sv
tb/debug_module_abstract_commands_core_tb.sv
